/* hdl/tee_pkg.sv */
// ----------------------------------------------------------------------------
// tee_pkg
// Types and character constants shared by the text escape encoder stages.
// ----------------------------------------------------------------------------
package tee_pkg;

   // Escape class picked by the classify stage
   typedef enum logic [2:0] {
      CLS_PLAIN,
      CLS_ESC,
      CLS_NUMREF,
      CLS_APOS,
      CLS_QUOT
   } cls_type;

   localparam logic [7:0] CHR_BSLASH = 8'h5C;
   localparam logic [7:0] CHR_AMP    = 8'h26;
   localparam logic [7:0] CHR_HASH   = 8'h23;
   localparam logic [7:0] CHR_SEMI   = 8'h3B;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_SQUOTE = 8'h27;
   localparam logic [7:0] CHR_DQUOTE = 8'h22;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_CR     = 8'h0D;
   localparam logic [7:0] CHR_BS     = 8'h08;
   localparam logic [7:0] CTRL_LIMIT = 8'd32;
   localparam logic [7:0] ASCII_MAX  = 8'd127;

   localparam logic [2:0] SEQ_LEN_MAX = 3'd6;

   // Element 0 is the first byte sent, so the literals read backwards
   localparam logic [5:0][7:0] APOS_SEQ = ";sopa&";
   localparam logic [5:0][7:0] QUOT_SEQ = ";touq&";

   typedef struct packed {
      logic [7:0] code;
      logic       text_end;
      cls_type    cls;
      logic [7:0] letter;
   } tee_item_type;

   typedef struct packed {
      tee_item_type item;
      logic [1:0]   hund;
      logic [3:0]   tens;
      logic [3:0]   ones;
   } tee_dec_type;

   typedef struct packed {
      logic [5:0][7:0] seq;
      logic [2:0]      len;
      logic            text_end;
   } tee_seq_type;

endpackage

/* hdl/tee_classify.sv */
// ----------------------------------------------------------------------------
// tee_classify
// First stage: sorts the byte into its escape class and picks the letter
// of a backslash escape.
// ----------------------------------------------------------------------------
module tee_classify import tee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [7:0]   in_byte,
   input  logic         in_text_end,
   output logic         out_valid,
   input  logic         out_stall,
   output tee_item_type out_item
);

   logic         valid_ff;
   tee_item_type item_ff;
   tee_item_type item_in;

   always_comb begin
      item_in.code     = in_byte;
      item_in.text_end = in_text_end;
      item_in.letter   = 8'h00;
      priority if (in_byte > ASCII_MAX || in_byte == CHR_BSLASH) begin
         item_in.cls = CLS_NUMREF;
      end else if (in_byte < CTRL_LIMIT) begin
         item_in.cls = CLS_ESC;
         priority if (in_byte == CHR_NL) begin
            item_in.letter = "n";
         end else if (in_byte == CHR_TAB) begin
            item_in.letter = "t";
         end else if (in_byte == CHR_CR) begin
            item_in.letter = "r";
         end else if (in_byte == CHR_BS) begin
            item_in.letter = "b";
         end else begin
            item_in.cls = CLS_NUMREF;
         end
      end else if (in_byte == CHR_SQUOTE) begin
         item_in.cls = CLS_APOS;
      end else if (in_byte == CHR_DQUOTE) begin
         item_in.cls = CLS_QUOT;
      end else begin
         item_in.cls = CLS_PLAIN;
      end
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
      if (!in_stall && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* hdl/tee_decimal.sv */
// ----------------------------------------------------------------------------
// tee_decimal
// Two stages that split the byte into hundreds, tens and ones digits.
// ----------------------------------------------------------------------------
module tee_decimal import tee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  tee_item_type in_item,
   output logic         out_valid,
   input  logic         out_stall,
   output tee_dec_type  out_dec
);

   // stage A: hundreds digit and remainder below 100
   logic         a_valid_ff;
   tee_item_type a_item_ff;
   logic [1:0]   a_hund_ff;
   logic [6:0]   a_rem_ff;
   logic [1:0]   a_hund_in;
   logic [6:0]   a_rem_in;
   logic         a_stall;

   // stage B: tens and ones digits
   logic         b_valid_ff;
   tee_dec_type  b_dec_ff;
   logic [14:0]  b_prod;
   logic [3:0]   b_tens;
   logic [6:0]   b_tens10;
   logic [3:0]   b_ones;
   logic         b_stall;

   always_comb begin
      priority if (in_item.code >= 8'd200) begin
         a_hund_in = 2'd2;
         a_rem_in  = 7'(in_item.code - 8'd200);
      end else if (in_item.code >= 8'd100) begin
         a_hund_in = 2'd1;
         a_rem_in  = 7'(in_item.code - 8'd100);
      end else begin
         a_hund_in = 2'd0;
         a_rem_in  = in_item.code[6:0];
      end
   end

   assign b_stall  = b_valid_ff && out_stall;
   assign a_stall  = a_valid_ff && b_stall;
   assign in_stall = a_stall;

   // x / 10 for x below 100 as (x * 205) >> 11
   assign b_prod   = {8'h00, a_rem_ff} * 15'd205;
   assign b_tens   = b_prod[14:11];
   assign b_tens10 = {b_tens, 3'b000} - 7'd0 + {2'b00, b_tens, 1'b0};
   assign b_ones   = 4'(a_rem_ff - b_tens10);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (!a_stall) begin
            a_valid_ff <= in_valid;
         end
         if (!b_stall) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (!a_stall && in_valid) begin
         a_item_ff <= in_item;
         a_hund_ff <= a_hund_in;
         a_rem_ff  <= a_rem_in;
      end
      if (!b_stall && a_valid_ff) begin
         b_dec_ff.item <= a_item_ff;
         b_dec_ff.hund <= a_hund_ff;
         b_dec_ff.tens <= b_tens;
         b_dec_ff.ones <= b_ones;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_dec   = b_dec_ff;

endmodule

/* hdl/tee_assemble.sv */
// ----------------------------------------------------------------------------
// tee_assemble
// Builds the escaped byte run and its length from class and digits.
// ----------------------------------------------------------------------------
module tee_assemble import tee_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  tee_dec_type in_dec,
   output logic        out_valid,
   input  logic        out_stall,
   output tee_seq_type out_seq
);

   logic        valid_ff;
   tee_seq_type seq_ff;
   tee_seq_type seq_in;
   logic [7:0]  chr_hund;
   logic [7:0]  chr_tens;
   logic [7:0]  chr_ones;

   assign chr_hund = CHR_ZERO | {6'b000000, in_dec.hund};
   assign chr_tens = CHR_ZERO | {4'h0, in_dec.tens};
   assign chr_ones = CHR_ZERO | {4'h0, in_dec.ones};

   always_comb begin
      seq_in.seq      = '0;
      seq_in.len      = 3'd1;
      seq_in.text_end = in_dec.item.text_end;
      unique case (in_dec.item.cls)
         CLS_PLAIN: begin
            seq_in.seq[0] = in_dec.item.code;
            seq_in.len    = 3'd1;
         end
         CLS_ESC: begin
            seq_in.seq[0] = CHR_BSLASH;
            seq_in.seq[1] = in_dec.item.letter;
            seq_in.len    = 3'd2;
         end
         CLS_APOS: begin
            seq_in.seq = APOS_SEQ;
            seq_in.len = SEQ_LEN_MAX;
         end
         CLS_QUOT: begin
            seq_in.seq = QUOT_SEQ;
            seq_in.len = SEQ_LEN_MAX;
         end
         CLS_NUMREF: begin
            seq_in.seq[0] = CHR_AMP;
            seq_in.seq[1] = CHR_HASH;
            // no leading zeros
            priority if (in_dec.hund != 2'd0) begin
               seq_in.seq[2] = chr_hund;
               seq_in.seq[3] = chr_tens;
               seq_in.seq[4] = chr_ones;
               seq_in.seq[5] = CHR_SEMI;
               seq_in.len    = 3'd6;
            end else if (in_dec.tens != 4'd0) begin
               seq_in.seq[2] = chr_tens;
               seq_in.seq[3] = chr_ones;
               seq_in.seq[4] = CHR_SEMI;
               seq_in.len    = 3'd5;
            end else begin
               seq_in.seq[2] = chr_ones;
               seq_in.seq[3] = CHR_SEMI;
               seq_in.len    = 3'd4;
            end
         end
         default: begin
            seq_in.seq[0] = in_dec.item.code;
            seq_in.len    = 3'd1;
         end
      endcase
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
      if (!in_stall && in_valid) begin
         seq_ff <= seq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_seq   = seq_ff;

endmodule

/* hdl/tee_serializer.sv */
// ----------------------------------------------------------------------------
// tee_serializer
// Output register that shifts a byte run out one byte per transfer.
// ----------------------------------------------------------------------------
module tee_serializer import tee_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_stall,
   input  tee_seq_type in_seq,
   output logic        out_valid,
   input  logic        out_stall,
   output logic [7:0]  out_byte,
   output logic        out_run_last,
   output logic        out_stream_last
);

   logic [5:0][7:0] seq_ff;
   logic [2:0]      cnt_ff;
   logic            end_ff;
   logic            take;
   logic            last;
   logic            free;

   assign last     = (cnt_ff == 3'd1);
   assign take     = (cnt_ff != 3'd0) && !out_stall;
   // a new run loads when empty or as the last byte of this one leaves
   assign free     = (cnt_ff == 3'd0) || (take && last);
   assign in_stall = !free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (free) begin
         cnt_ff <= in_valid ? in_seq.len : 3'd0;
      end else if (take) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
      if (free && in_valid) begin
         seq_ff <= in_seq.seq;
         end_ff <= in_seq.text_end;
      end else if (take) begin
         seq_ff <= {8'h00, seq_ff[5:1]};
      end
   end

   assign out_valid       = (cnt_ff != 3'd0);
   assign out_byte        = seq_ff[0];
   assign out_run_last    = last;
   assign out_stream_last = last && end_ff;

endmodule

/* hdl/text_escape_encoder_unit.sv */
// ----------------------------------------------------------------------------
// text_escape_encoder_unit
// An input byte passes the classify, decimal A, decimal B, assemble and
// serializer registers before its first output byte. Throughput: one input
// byte per cycle while bytes pass unchanged and rsp_stall is low; an escaped
// byte holds the serializer for its run of 2, 4, 5 or 6 bytes, one per cycle.
// Reset clears all valid bits and the serializer count; data is not reset.
// ----------------------------------------------------------------------------
module text_escape_encoder_unit import tee_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_text_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_stream_last
);

   logic         cls_valid;
   logic         cls_stall;
   tee_item_type cls_item;
   logic         dec_valid;
   logic         dec_stall;
   tee_dec_type  dec_data;
   logic         asm_valid;
   logic         asm_stall;
   tee_seq_type  asm_seq;

   tee_classify u_classify (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .in_byte     (req_in_byte),
      .in_text_end (req_text_end),
      .out_valid   (cls_valid),
      .out_stall   (cls_stall),
      .out_item    (cls_item)
   );

   tee_decimal u_decimal (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_stall  (cls_stall),
      .in_item   (cls_item),
      .out_valid (dec_valid),
      .out_stall (dec_stall),
      .out_dec   (dec_data)
   );

   tee_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_stall  (dec_stall),
      .in_dec    (dec_data),
      .out_valid (asm_valid),
      .out_stall (asm_stall),
      .out_seq   (asm_seq)
   );

   tee_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (asm_valid),
      .in_stall        (asm_stall),
      .in_seq          (asm_seq),
      .out_valid       (rsp_valid),
      .out_stall       (rsp_stall),
      .out_byte        (rsp_out_byte),
      .out_run_last    (rsp_run_last),
      .out_stream_last (rsp_stream_last)
   );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_escape_encoder_unit. Random and directed text
// bytes are pushed through the request channel in bursts. Every accepted byte
// is expanded into its expected escaped run, and each output transfer is
// checked in order against that run, including both last flags.
// ----------------------------------------------------------------------------
module testbench import tee_pkg::*; ();

   localparam int RANDOM_ITEMS   = 138;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_MAX     = 10;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       stream_last;
   } esc_byte_type;

   class escape_scoreboard;
      esc_byte_type expected_bytes[$];
      int unsigned  mismatches;
      int unsigned  checked;

      function new();
         mismatches = 0;
         checked    = 0;
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      function cls_type classify(logic [7:0] code);
         if (code > ASCII_MAX || code == CHR_BSLASH) return CLS_NUMREF;
         if (code < CTRL_LIMIT) begin
            if (code == CHR_NL || code == CHR_TAB || code == CHR_CR || code == CHR_BS)
               return CLS_ESC;
            return CLS_NUMREF;
         end
         if (code == CHR_SQUOTE) return CLS_APOS;
         if (code == CHR_DQUOTE) return CLS_QUOT;
         return CLS_PLAIN;
      endfunction

      // Expand one input byte into its escaped run and queue it
      function void note_transfer(logic [7:0] code, logic text_end);
         logic [7:0]   run[$];
         esc_byte_type entry;
         string        word;
         int           hund;
         int           tens;
         int           ones;
         word = "";
         case (classify(code))
            CLS_PLAIN: run = {run, code};
            CLS_ESC: begin
               run = {run, CHR_BSLASH};
               case (code)
                  CHR_NL:  run = {run, 8'("n")};
                  CHR_TAB: run = {run, 8'("t")};
                  CHR_CR:  run = {run, 8'("r")};
                  default: run = {run, 8'("b")};
               endcase
            end
            CLS_NUMREF: begin
               hund = code / 100;
               tens = (code / 10) % 10;
               ones = code % 10;
               run = {run, CHR_AMP};
               run = {run, CHR_HASH};
               // no leading zeros
               if (hund != 0) run = {run, 8'(CHR_ZERO + 8'(hund))};
               if (hund != 0 || tens != 0) run = {run, 8'(CHR_ZERO + 8'(tens))};
               run = {run, 8'(CHR_ZERO + 8'(ones))};
               run = {run, CHR_SEMI};
            end
            CLS_APOS: word = "&apos;";
            default:  word = "&quot;";
         endcase
         for (int i = 0; i < word.len(); i++) run = {run, 8'(word[i])};
         for (int k = 0; k < run.size(); k++) begin
            entry.data        = run[k];
            entry.run_last    = (k == run.size() - 1);
            entry.stream_last = entry.run_last & text_end;
            expected_bytes    = {expected_bytes, entry};
         end
      endfunction

      function void check_byte(logic [7:0] data, logic run_last, logic stream_last);
         esc_byte_type want;
         checked++;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: unexpected output byte %02h run_last %0b stream_last %0b",
                        $realtime, data, run_last, stream_last);
            return;
         end
         want = expected_bytes.pop_front();
         if (want.data !== data || want.run_last !== run_last ||
             want.stream_last !== stream_last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: expected %02h/%0b/%0b, got %02h/%0b/%0b (byte/run/stream)",
                        $realtime, want.data, want.run_last, want.stream_last,
                        data, run_last, stream_last);
         end
      endfunction
   endclass

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte     = 8'h00;
   logic       req_text_end    = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_stream_last;

   escape_scoreboard sb = new();

   int unsigned sent_items    = 0;
   int unsigned escaped_items = 0;
   int unsigned texts         = 0;
   int unsigned idle_cycles   = 0;
   int unsigned stall_left    = 0;
   int unsigned stall_mode    = 0;

   logic [7:0] directed_codes[$] = '{
      8'd0, 8'd255, 8'd128, 8'd127, 8'd92, 8'd10, 8'd9, 8'd13, 8'd8, 8'd1, 8'd7,
      8'd12, 8'd31, 8'd32, 8'd34, 8'd39, 8'd65, 8'd99, 8'd100, 8'd126, 8'd199, 8'd250
   };

   text_escape_encoder_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_text_end    (req_text_end),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_last (rsp_stream_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver stall pattern: switches between free, light, heavy and periodic
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 40);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 99) < 30);
         2:       rsp_stall <= ($urandom_range(0, 99) < 75);
         default: rsp_stall <= (stall_left[1:0] == 2'd0);
      endcase
   end

   // Transfer monitor and watchdog
   always @(posedge clock) begin : monitor
      bit progress;
      progress = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_transfer(req_in_byte, req_text_end);
            sent_items++;
            if (sb.classify(req_in_byte) != CLS_PLAIN) escaped_items++;
            if (req_text_end) texts++;
            progress = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_byte(rsp_out_byte, rsp_run_last, rsp_stream_last);
            progress = 1'b1;
         end
         if (progress) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] code, input logic text_end);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_in_byte  <= code;
      req_text_end <= text_end;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wiggle the idle payload
   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid    <= 1'b0;
         req_in_byte  <= 8'($urandom);
         req_text_end <= 1'($urandom);
      end
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int          burst_left;
      int          pick;
      logic [7:0]  code;
      logic [7:0]  specials[$];
      specials = '{CHR_SQUOTE, CHR_DQUOTE, CHR_BSLASH, CHR_NL, CHR_TAB, CHR_CR, CHR_BS};
      burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_codes[i])
         send_byte(directed_codes[i], (i % 5 == 4) || (i == directed_codes.size() - 1));

      // let the pipe empty completely before the random part
      pause_sender(1);
      wait_drained();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
         end
         if (i == RANDOM_ITEMS / 2) begin
            pause_sender(1);
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 45)      code = 8'($urandom_range(32, 126));
         else if (pick < 60) code = specials[$urandom_range(0, specials.size() - 1)];
         else if (pick < 75) code = 8'($urandom_range(128, 255));
         else if (pick < 85) code = 8'($urandom_range(0, 31));
         else                code = 8'($urandom_range(0, 255));
         send_byte(code, ($urandom_range(0, 7) == 0));
         burst_left--;
      end

      pause_sender(1);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d text bytes in %0d texts, %0d of them escaped.",
               sent_items, texts, escaped_items);
      $display("Checked %0d output bytes, %0d mismatches.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
